@@ rtl/core/u8u16_pkg.sv @@
// Package for the UTF-8 to UTF-16 stream decoder.
// Holds the queue word type and the per-byte decode function.
// No dependencies.
`default_nettype none

package u8u16_pkg;

	localparam int unsigned QDEPTH_DEFAULT = 2;
	localparam logic [15:0] REPL_UNIT = 16'h003F;
	localparam int unsigned MAX_RES = 3;

	// One queue word: all results caused by one input byte.
	typedef struct packed {
		logic [1:0]                count;   // 1..3 results
		logic [MAX_RES-1:0][15:0]  unit;
		logic [MAX_RES-1:0]        repl;
		logic                      last;    // byte closed the text
	} entry_t;

	typedef struct packed {
		entry_t     ent;
		logic [1:0] left;
		logic [7:0] lead;
		logic [7:0] second;
	} dec_t;

	function automatic logic is_cont(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

	// Decode held bytes plus the new byte. At most three steps, each
	// consumes one or more bytes or stops on an open sequence.
	function automatic dec_t decode_run(input logic [1:0] held_count,
		input logic [7:0] lead, input logic [7:0] second,
		input logic [7:0] data, input logic last);
		logic [63:0] bytes_v;
		logic [2:0]  n;
		logic [2:0]  pos;
		logic [2:0]  rem;
		logic [1:0]  k;
		logic        stop;
		logic [7:0]  c;
		logic [7:0]  c1;
		logic [7:0]  c2;
		dec_t        r;
		bytes_v = '0;
		r       = '0;
		pos     = '0;
		k       = '0;
		stop    = 1'b0;
		case (held_count)
			2'd0: begin
				bytes_v[7:0] = data;
				n = 3'd1;
			end
			2'd1: begin
				bytes_v[15:0] = {data, lead};
				n = 3'd2;
			end
			default: begin
				bytes_v[23:0] = {data, second, lead};
				n = 3'd3;
			end
		endcase
		for (int i = 0; i < 3; i++) begin
			if (!stop && pos < n) begin
				c   = bytes_v[{pos, 3'b000} +: 8];
				c1  = bytes_v[{pos + 3'd1, 3'b000} +: 8];
				c2  = bytes_v[{pos + 3'd2, 3'b000} +: 8];
				rem = n - pos;
				if (!c[7]) begin
					r.ent.unit[k] = {8'h00, c};
					k   = k + 2'd1;
					pos = pos + 3'd1;
				end else if (c[7:5] == 3'b110) begin
					if (rem < 3'd2) begin
						stop = 1'b1;
					end else if (is_cont(c1)) begin
						r.ent.unit[k] = {5'b00000, c[4:0], c1[5:0]};
						k   = k + 2'd1;
						pos = pos + 3'd2;
					end else begin
						r.ent.unit[k] = REPL_UNIT;
						r.ent.repl[k] = 1'b1;
						k   = k + 2'd1;
						pos = pos + 3'd1;
					end
				end else if (c[7:4] == 4'b1110) begin
					if (rem < 3'd2) begin
						stop = 1'b1;
					end else if (!is_cont(c1)) begin
						r.ent.unit[k] = REPL_UNIT;
						r.ent.repl[k] = 1'b1;
						k   = k + 2'd1;
						pos = pos + 3'd1;
					end else if (rem < 3'd3) begin
						stop = 1'b1;
					end else if (is_cont(c2)) begin
						r.ent.unit[k] = {c[3:0], c1[5:0], c2[5:0]};
						k   = k + 2'd1;
						pos = pos + 3'd3;
					end else begin
						r.ent.unit[k] = REPL_UNIT;
						r.ent.repl[k] = 1'b1;
						k   = k + 2'd1;
						pos = pos + 3'd1;
					end
				end else begin
					r.ent.unit[k] = REPL_UNIT;
					r.ent.repl[k] = 1'b1;
					k   = k + 2'd1;
					pos = pos + 3'd1;
				end
			end
		end
		// flush whatever is still open at end of text
		if (last) begin
			for (int j = 0; j < 3; j++) begin
				if (pos < n) begin
					r.ent.unit[k] = REPL_UNIT;
					r.ent.repl[k] = 1'b1;
					k   = k + 2'd1;
					pos = pos + 3'd1;
				end
			end
		end
		r.ent.count = k;
		r.ent.last  = last;
		r.left      = 2'(n - pos);
		r.lead      = (r.left >= 2'd1) ? bytes_v[{pos, 3'b000} +: 8] : 8'h00;
		r.second    = (r.left >= 2'd2) ? bytes_v[{pos + 3'd1, 3'b000} +: 8] : 8'h00;
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/u8u16_byte_if.sv @@
// Input channel of the decoder: one UTF-8 byte per word.
// No dependencies.
`default_nettype none

interface u8u16_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_text;

	modport source (output valid, output data_byte, output end_of_text, input ready);
	modport sink (input valid, input data_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

@@ rtl/core/u8u16_unit_if.sv @@
// Output channel of the decoder: one UTF-16 code unit per word.
// No dependencies.
`default_nettype none

interface u8u16_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        replaced;
	logic        run_end;
	logic        text_end;

	modport source (output valid, output code_unit, output replaced, output run_end,
		output text_end, input ready);
	modport sink (input valid, input code_unit, input replaced, input run_end,
		input text_end, output ready);
endinterface

`default_nettype wire

@@ rtl/core/u8u16_front.sv @@
// Front end: takes bytes, keeps the open sequence, builds at most one queue word per byte.
// Depends on u8u16_pkg and u8u16_byte_if.
`default_nettype none

module u8u16_front (
	input  wire                   clk,
	input  wire                   arst_n,
	u8u16_byte_if.sink            byte_ch,
	input  wire                   push_ready,
	output logic                  push_valid,
	output u8u16_pkg::entry_t     push_ent,
	output logic [1:0]            held_count
);
	import u8u16_pkg::*;

	logic [1:0] held_count_q;
	logic [7:0] held_lead_q;
	logic [7:0] held_second_q;
	logic       accept;
	dec_t       dec;

	assign byte_ch.ready = push_ready;
	assign accept        = byte_ch.valid && push_ready;
	assign dec           = decode_run(held_count_q, held_lead_q, held_second_q,
		byte_ch.data_byte, byte_ch.end_of_text);

	// a byte that only extends an open sequence produces no word
	assign push_valid = accept && (dec.ent.count != 2'd0);
	assign push_ent   = dec.ent;
	assign held_count = held_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q  <= 2'd0;
			held_lead_q   <= 8'h00;
			held_second_q <= 8'h00;
		end else if (accept) begin
			held_count_q  <= dec.left;
			held_lead_q   <= dec.lead;
			held_second_q <= dec.second;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/u8u16_queue.sv @@
// Small word queue between front and back end.
// Depends on u8u16_pkg.
`default_nettype none

module u8u16_queue #(
	parameter int unsigned DEPTH = u8u16_pkg::QDEPTH_DEFAULT
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push_valid,
	input  wire u8u16_pkg::entry_t push_ent,
	output logic                  push_ready,
	output logic                  pop_valid,
	output u8u16_pkg::entry_t     pop_ent,
	input  wire                   pop_ready
);
	import u8u16_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	entry_t          ent_q [DEPTH];
	logic [AW-1:0]   wptr_q;
	logic [AW-1:0]   rptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_ent    = ent_q[rptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/u8u16_back.sv @@
// Back end: holds one queue word and sends its code units one per cycle while unit_ch.ready is high.
// Depends on u8u16_pkg and u8u16_unit_if.
`default_nettype none

module u8u16_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   pop_valid,
	input  wire u8u16_pkg::entry_t pop_ent,
	output logic                  pop_ready,
	u8u16_unit_if.source          unit_ch
);
	import u8u16_pkg::*;

	entry_t     ent_q;
	logic       busy_q;
	logic [1:0] idx_q;
	logic       is_last_unit;
	logic       sent;

	assign is_last_unit = (idx_q == ent_q.count - 2'd1);
	assign sent         = busy_q && unit_ch.ready;
	// reload as the last unit of the current word leaves
	assign pop_ready    = !busy_q || (sent && is_last_unit);

	assign unit_ch.valid     = busy_q;
	assign unit_ch.code_unit = ent_q.unit[idx_q];
	assign unit_ch.replaced  = ent_q.repl[idx_q];
	assign unit_ch.run_end   = is_last_unit;
	assign unit_ch.text_end  = is_last_unit && ent_q.last;

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			ent_q <= pop_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (pop_ready) begin
			busy_q <= pop_valid;
			idx_q  <= 2'd0;
		end else if (sent) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/utf8_to_utf16_stream_decoder.sv @@
// Top level of the UTF-8 to UTF-16 stream decoder (BMP only).
// Depends on u8u16_pkg, u8u16_byte_if, u8u16_unit_if, u8u16_front,
// u8u16_queue and u8u16_back.
//
//   channel   dir   word contents
//   byte_ch   in    data_byte[7:0], end_of_text
//   unit_ch   out   code_unit[15:0], replaced, run_end, text_end
//
// One byte is taken per cycle while the queue has room; a byte gives 0 to 3 code units.
// The output port sends one code unit per cycle while unit_ch.ready is high, so a byte giving k units
// holds it for all k of them; QUEUE_DEPTH words between front and back absorb that.
// The first code unit is offered once its word has passed the queue and the back-end word register.
// Reset clears the held sequence and empties the queue and the output register.
// byte_ch.ready drops only when the queue is full.
`default_nettype none

module utf8_to_utf16_stream_decoder #(
	parameter int unsigned QUEUE_DEPTH = u8u16_pkg::QDEPTH_DEFAULT
) (
	input  wire            clk,
	input  wire            arst_n,
	u8u16_byte_if.sink     byte_ch,
	u8u16_unit_if.source   unit_ch
);
	import u8u16_pkg::*;

	logic       push_valid;
	logic       push_ready;
	entry_t     push_ent;
	logic       pop_valid;
	logic       pop_ready;
	entry_t     pop_ent;
	logic [1:0] held_count;

	u8u16_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_ch    (byte_ch),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_ent   (push_ent),
		.held_count (held_count)
	);

	u8u16_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ent   (push_ent),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_ent    (pop_ent),
		.pop_ready  (pop_ready)
	);

	u8u16_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ent   (pop_ent),
		.pop_ready (pop_ready),
		.unit_ch   (unit_ch)
	);

	// end of text always leaves nothing held
	a_eot_flush: assert property (@(posedge clk) disable iff (!arst_n)
		byte_ch.valid && byte_ch.ready && byte_ch.end_of_text |=> held_count == 2'd0)
		else $error("held bytes remain after end of text");

	// an end-of-text byte always produces a word
	a_eot_push: assert property (@(posedge clk) disable iff (!arst_n)
		byte_ch.valid && byte_ch.ready && byte_ch.end_of_text |-> push_valid)
		else $error("end-of-text byte produced no result");

	a_text_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		unit_ch.valid && unit_ch.text_end |-> unit_ch.run_end)
		else $error("text_end without run_end");

	a_repl_unit: assert property (@(posedge clk) disable iff (!arst_n)
		unit_ch.valid && unit_ch.replaced |-> unit_ch.code_unit == REPL_UNIT)
		else $error("replacement word carries wrong code unit");

	// words in the back end never carry a zero count
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid |-> pop_ent.count != 2'd0)
		else $error("empty word in queue");

endmodule

`default_nettype wire

@@ bench/u8u16_decode_checker.sv @@
// Scoreboard for the UTF-8 to UTF-16 stream decoder: watches both channels,
// predicts the code units of every accepted byte and compares them in order.
// Depends on u8u16_pkg, u8u16_byte_if and u8u16_unit_if.

module u8u16_decode_checker (
	input  wire    clk,
	input  wire    arst_n,
	u8u16_byte_if  byte_mon,
	u8u16_unit_if  unit_mon,
	output int     fail_count,
	output int     pending,
	output int     bytes_seen,
	output int     units_seen,
	output int     repl_seen
);
	import u8u16_pkg::*;

	typedef struct packed {
		logic [15:0] unit;
		logic        repl;
		logic        run_end;
		logic        text_end;
	} unit_word_t;

	unit_word_t expected_units[$];

	// bytes of an unfinished sequence
	logic [1:0] held_n;
	logic [7:0] held_b0;
	logic [7:0] held_b1;

	int fails;
	int reported;
	int n_bytes;
	int n_units;
	int n_repl;

	function automatic logic is_trail(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

	function automatic void push_unit(input logic [15:0] u, input logic r);
		expected_units.push_back('{unit: u, repl: r, run_end: 1'b0, text_end: 1'b0});
	endfunction

	// Held bytes are replayed ahead of the new byte; a bad lead costs one '?'
	// and decoding restarts right after it.
	task automatic decode_byte(input logic [7:0] b, input logic eot);
		logic [7:0] seq [3];
		logic [7:0] c;
		int n;
		int pos;
		int rem;
		int first;
		n = 0;
		pos = 0;
		first = expected_units.size();
		if (held_n >= 2'd1) begin
			seq[n] = held_b0;
			n++;
		end
		if (held_n >= 2'd2) begin
			seq[n] = held_b1;
			n++;
		end
		seq[n] = b;
		n++;
		while (pos < n) begin
			c = seq[pos];
			rem = n - pos;
			if (!c[7]) begin
				push_unit({8'h00, c}, 1'b0);
				pos += 1;
			end else if (c[7:5] == 3'b110) begin
				if (rem < 2)
					break;
				if (is_trail(seq[pos+1])) begin
					push_unit({5'b00000, c[4:0], seq[pos+1][5:0]}, 1'b0);
					pos += 2;
				end else begin
					push_unit(REPL_UNIT, 1'b1);
					pos += 1;
				end
			end else if (c[7:4] == 4'b1110) begin
				if (rem < 2)
					break;
				if (!is_trail(seq[pos+1])) begin
					push_unit(REPL_UNIT, 1'b1);
					pos += 1;
				end else if (rem < 3) begin
					break;
				end else if (is_trail(seq[pos+2])) begin
					push_unit({c[3:0], seq[pos+1][5:0], seq[pos+2][5:0]}, 1'b0);
					pos += 3;
				end else begin
					push_unit(REPL_UNIT, 1'b1);
					pos += 1;
				end
			end else begin
				push_unit(REPL_UNIT, 1'b1);
				pos += 1;
			end
		end
		// end of text flushes whatever is still open
		if (eot) begin
			while (pos < n) begin
				push_unit(REPL_UNIT, 1'b1);
				pos += 1;
			end
		end
		held_n = 2'(n - pos);
		held_b0 = 8'h00;
		held_b1 = 8'h00;
		if (n - pos >= 1)
			held_b0 = seq[pos];
		if (n - pos >= 2)
			held_b1 = seq[pos+1];
		if (expected_units.size() > first) begin
			expected_units[expected_units.size()-1].run_end = 1'b1;
			expected_units[expected_units.size()-1].text_end = eot;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		unit_word_t want;
		if (!arst_n) begin
			expected_units.delete();
			held_n = 2'd0;
			held_b0 = 8'h00;
			held_b1 = 8'h00;
			fails = 0;
			reported = 0;
			n_bytes = 0;
			n_units = 0;
			n_repl = 0;
		end else begin
			if (unit_mon.valid && unit_mon.ready) begin
				n_units++;
				if (unit_mon.replaced)
					n_repl++;
				if (expected_units.size() == 0) begin
					fails++;
					if (reported < 10) begin
						reported++;
						$display("unexpected code unit %h (repl %b) with nothing pending",
							unit_mon.code_unit, unit_mon.replaced);
					end
				end else begin
					want = expected_units.pop_front();
					if (unit_mon.code_unit !== want.unit || unit_mon.replaced !== want.repl ||
						unit_mon.run_end !== want.run_end ||
						unit_mon.text_end !== want.text_end) begin
						fails++;
						if (reported < 10) begin
							reported++;
							$display("unit %0d: exp %h/%b/%b/%b got %h/%b/%b/%b",
								n_units, want.unit, want.repl, want.run_end, want.text_end,
								unit_mon.code_unit, unit_mon.replaced, unit_mon.run_end,
								unit_mon.text_end);
						end
					end
				end
			end
			if (byte_mon.valid && byte_mon.ready) begin
				n_bytes++;
				decode_byte(byte_mon.data_byte, byte_mon.end_of_text);
			end
		end
		fail_count <= fails;
		pending <= expected_units.size();
		bytes_seen <= n_bytes;
		units_seen <= n_units;
		repl_seen <= n_repl;
	end

endmodule

@@ bench/tb_utf8_to_utf16_stream_decoder.sv @@
// Testbench top for the UTF-8 to UTF-16 stream decoder: drives bytes in bursts,
// stalls the output side and gives the verdict from u8u16_decode_checker.
// Depends on u8u16_byte_if, u8u16_unit_if, the decoder and the checker.

module tb_utf8_to_utf16_stream_decoder;

	localparam int NUM_ITEMS   = 230;
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_LIMIT = 5000;
	localparam int TIMEOUT     = 2_000_000;

	typedef enum {RX_FULL, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	// {end_of_text, data_byte}
	localparam logic [8:0] DIRECTED_BYTES [25] = '{
		9'h000, 9'h07F,                   // zero byte, top of ASCII
		9'h0C2, 9'h0A9,                   // two-byte
		9'h0E2, 9'h082, 9'h0AC,           // three-byte
		9'h0EF, 9'h0BF, 9'h0BF,           // largest three-byte
		9'h080, 9'h0FF, 9'h0F0, 9'h0F8,   // stray trail, unsupported leads
		9'h0C3, 9'h041,                   // two-byte lead broken by ASCII
		9'h0E2, 9'h082, 9'h041,           // bad third byte: three units at once
		9'h0E2, 9'h182,                   // text ends with two bytes held
		9'h0C0, 9'h080,                   // overlong form
		9'h1C3,                           // text ends on a lone lead
		9'h141                            // text ends on ASCII
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic rx_hold;
	int   cycle_count = 0;
	int   bytes_sent;
	int   burst_left;

	int chk_fails;
	int chk_pending;
	int chk_bytes;
	int chk_units;
	int chk_repl;

	u8u16_byte_if byte_ch ();
	u8u16_unit_if unit_ch ();

	always #5 clk = ~clk;

	utf8_to_utf16_stream_decoder u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_ch (byte_ch),
		.unit_ch (unit_ch)
	);

	u8u16_decode_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_mon   (byte_ch),
		.unit_mon   (unit_ch),
		.fail_count (chk_fails),
		.pending    (chk_pending),
		.bytes_seen (chk_bytes),
		.units_seen (chk_units),
		.repl_seen  (chk_repl)
	);

	// output side: the stall pattern steps through four modes as cycle_count advances
	always @(posedge clk) begin
		if (rx_hold) begin
			unit_ch.ready <= 1'b0;
		end else begin
			case (rx_mode_t'((cycle_count >> 6) % 4))
				RX_FULL:     unit_ch.ready <= 1'b1;
				RX_MOSTLY:   unit_ch.ready <= ($urandom_range(0, 3) != 0);
				RX_SPARSE:   unit_ch.ready <= ($urandom_range(0, 9) < 3);
				RX_PERIODIC: unit_ch.ready <= (cycle_count % 5 != 0);
				default:     unit_ch.ready <= 1'b1;
			endcase
		end
		cycle_count <= cycle_count + 1;
	end

	// long hold-off while the input keeps offering bytes, to fill the queue
	initial begin
		rx_hold = 1'b0;
		wait (bytes_sent >= 90);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#(TIMEOUT);
		$display("timeout with %0d code units pending", chk_pending);
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [7:0] trail_byte();
		return 8'($urandom_range(8'h80, 8'hBF));
	endfunction

	// call at a rising edge; returns at the edge where the word was taken
	task automatic send_byte(input logic [7:0] b, input logic eot);
		logic taken;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				byte_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 50)
				: $urandom_range(1, 12);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.end_of_text <= eot;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = byte_ch.ready;
			@(posedge clk);
		end
		bytes_sent++;
		burst_left--;
	endtask

	// mostly well-formed sequences with random payload, some cut short or noise
	task automatic send_sequence();
		int   kind;
		logic eot;
		kind = $urandom_range(0, 99);
		eot = ($urandom_range(0, 11) == 0);
		if (kind < 30) begin
			send_byte(8'($urandom_range(0, 127)), eot);
		end else if (kind < 55) begin
			send_byte(8'($urandom_range(8'hC0, 8'hDF)), 1'b0);
			send_byte(trail_byte(), eot);
		end else if (kind < 82) begin
			send_byte(8'($urandom_range(8'hE0, 8'hEF)), 1'b0);
			send_byte(trail_byte(), 1'b0);
			send_byte(trail_byte(), eot);
		end else if (kind < 90) begin
			if ($urandom_range(0, 1) == 0) begin
				send_byte(8'($urandom_range(8'hC0, 8'hDF)), eot);
			end else begin
				send_byte(8'($urandom_range(8'hE0, 8'hEF)), 1'b0);
				send_byte(trail_byte(), eot);
			end
		end else begin
			send_byte(8'($urandom_range(0, 255)), eot);
		end
	endtask

	initial begin
		int guard;
		int total_fails;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = 8'h00;
		byte_ch.end_of_text = 1'b0;
		unit_ch.ready = 1'b0;
		bytes_sent = 0;
		burst_left = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_BYTES[i])
			send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);
		while (bytes_sent < NUM_ITEMS)
			send_sequence();
		byte_ch.valid <= 1'b0;

		// let the checker count the last byte before polling its backlog
		repeat (2) @(posedge clk);
		guard = 0;
		while (chk_pending != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);

		total_fails = chk_fails + chk_pending;
		if (chk_pending != 0)
			$display("%0d code units never arrived", chk_pending);
		$display("%0d bytes in, %0d code units checked, %0d of them replacements",
			chk_bytes, chk_units, chk_repl);
		$display("output side stalled in four patterns plus one %0d-cycle hold-off",
			HOLD_CYCLES);
		if (total_fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
